FILE: rtl/hfr_pkg.sv
// Shared types and constants for the histogram frequency ranker.
// No dependencies; imported by the interfaces, the top level and the testbench.
`timescale 1ns / 1ps

package hfr_pkg;

    // Depth of one pool's slice of the count store, and its index width
    localparam int STORE_DEPTH = 64;
    localparam int IDX_BITS    = 6;

    // Request codes
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_RANK = 1'b1;

    // Result status codes
    localparam logic ST_OK     = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic       pool;
        logic [5:0] sample_value;
    } t_req;

    typedef struct packed {
        logic       status;
        logic [5:0] rank_pos;
        logic [5:0] bin_value;
        logic [7:0] bin_count;
        logic       last;
    } t_res;

endpackage

FILE: rtl/hfr_req_if.sv
// Valid/ready channel carrying request words.
// Depends on hfr_pkg for the payload type.
`timescale 1ns / 1ps

interface hfr_req_if;
    import hfr_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/hfr_res_if.sv
// Valid/ready channel carrying result words.
// Depends on hfr_pkg for the payload type.
`timescale 1ns / 1ps

interface hfr_res_if;
    import hfr_pkg::*;

    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/histogram_frequency_ranker.sv
// Add: accept (count read), then read-modify-write and one result word.
// Rank over N bins: each bin is placed by a sweep over every bin (one compare per cycle
// through the second count-store read port), then each result word takes an
// order-store read, a count read and the output step, in that order.
// Synchronous active-low reset clears control and the per-entry valid bits,
// so all counts read as zero right after reset; no clearing pass is needed.
`timescale 1ns / 1ps

module histogram_frequency_ranker #(
    parameter int MAIN_BINS  = 64,
    parameter int BONUS_BINS = 32,
    parameter int COUNT_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hfr_req_if.sink   i_req,
    hfr_res_if.source o_res
);
    import hfr_pkg::*;

    localparam int MAIN_N  = (MAIN_BINS  > STORE_DEPTH) ? STORE_DEPTH : MAIN_BINS;
    localparam int BONUS_N = (BONUS_BINS > STORE_DEPTH) ? STORE_DEPTH : BONUS_BINS;
    localparam int ADDR_BITS = IDX_BITS + 1;
    localparam int MEM_DEPTH = 2 * STORE_DEPTH;
    localparam logic [IDX_BITS-1:0] MAIN_LAST  = IDX_BITS'(MAIN_N - 1);
    localparam logic [IDX_BITS-1:0] BONUS_LAST = IDX_BITS'(BONUS_N - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_ADD   = 9'b000000010,
        ST_RK_I  = 9'b000000100,
        ST_RK_SW = 9'b000001000,
        ST_RK_TL = 9'b000010000,
        ST_OUT_A = 9'b000100000,
        ST_OUT_B = 9'b001000000,
        ST_OUT_C = 9'b010000000,
        ST_SPARE = 9'b100000000
    } t_state;

    // Count store: both pools, address {pool, bin}, valid bit per entry
    logic [COUNT_BITS-1:0] r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]  r_vld;
    logic [COUNT_BITS-1:0] r_rda, r_rdb;
    logic                  r_rda_v, r_rdb_v;

    // Rank order store
    logic [IDX_BITS-1:0] r_ro_mem [STORE_DEPTH];
    logic [IDX_BITS-1:0] r_ro;

    t_state r_state, n_state;
    logic   r_ov, n_ov;
    t_res   r_od, n_od;
    logic   r_pool, n_pool;
    logic [IDX_BITS-1:0] r_val, n_val;
    logic [IDX_BITS-1:0] r_i, n_i, r_j, n_j, r_jq, r_k, n_k, r_pos, n_pos;
    logic   r_vq;

    logic                  a_en, b_en, w_en, ro_wen;
    logic [ADDR_BITS-1:0]  a_addr, b_addr, w_addr;
    logic [COUNT_BITS-1:0] w_data, cnt_a, cnt_b, cnt_inc;
    logic [IDX_BITS-1:0]   last_idx;
    logic                  slot_free, reject, ahead, accept;

    // Report a count, capped to the 8-bit field
    function automatic logic [7:0] cap_count(input logic [COUNT_BITS-1:0] c);
        logic [15:0] ext;
        ext = 16'(c);
        return (ext > 16'd255) ? 8'd255 : ext[7:0];
    endfunction

    assign accept    = i_req.valid && i_req.ready;
    assign slot_free = !r_ov || o_res.ready;
    assign last_idx  = r_pool ? BONUS_LAST : MAIN_LAST;
    assign cnt_a     = r_rda_v ? r_rda : '0;
    assign cnt_b     = r_rdb_v ? r_rdb : '0;
    assign cnt_inc   = (cnt_a == CNT_MAX) ? cnt_a : cnt_a + 1'b1;
    assign reject    = (r_val == '0) || (r_val > last_idx);
    // Bin j is ahead of bin i: higher count, or same count and lower value
    assign ahead     = (cnt_b > cnt_a) || ((cnt_b == cnt_a) && (r_jq < r_i));

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_ov;
    assign o_res.data  = r_od;

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_ov    = r_ov && !o_res.ready;
        n_od    = r_od;
        n_pool  = r_pool;
        n_val   = r_val;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_pos   = r_vq ? r_pos + IDX_BITS'(ahead) : r_pos;
        a_en    = 1'b0;
        a_addr  = {r_pool, r_i};
        b_en    = 1'b0;
        b_addr  = {r_pool, r_j};
        w_en    = 1'b0;
        w_addr  = {r_pool, r_val};
        w_data  = cnt_inc;
        ro_wen  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_pool = i_req.data.pool;
                    n_val  = i_req.data.sample_value;
                    if (i_req.data.req_type == REQ_ADD) begin
                        a_en    = 1'b1;
                        a_addr  = {i_req.data.pool, i_req.data.sample_value};
                        n_state = ST_ADD;
                    end else begin
                        n_i     = '0;
                        n_state = ST_RK_I;
                    end
                end
            end
            ST_ADD: begin
                if (slot_free) begin
                    n_ov             = 1'b1;
                    n_od.status      = reject ? ST_REJECT : ST_OK;
                    n_od.rank_pos    = '0;
                    n_od.bin_value   = r_val;
                    n_od.bin_count   = reject ? 8'd0 : cap_count(cnt_inc);
                    n_od.last        = 1'b1;
                    w_en             = !reject;
                    n_state          = ST_IDLE;
                end
            end
            ST_RK_I: begin
                // Fetch count of bin i, reset position and sweep index
                a_en    = 1'b1;
                n_j     = '0;
                n_pos   = '0;
                n_state = ST_RK_SW;
            end
            ST_RK_SW: begin
                b_en = 1'b1;
                n_j  = r_j + 1'b1;
                if (r_j == last_idx) begin
                    n_state = ST_RK_TL;
                end
            end
            ST_RK_TL: begin
                // Last compare lands now; place bin i
                ro_wen = 1'b1;
                if (r_i == last_idx) begin
                    n_k     = '0;
                    n_state = ST_OUT_A;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_RK_I;
                end
            end
            ST_OUT_A: begin
                n_state = ST_OUT_B;
            end
            ST_OUT_B: begin
                a_en    = 1'b1;
                a_addr  = {r_pool, r_ro};
                n_state = ST_OUT_C;
            end
            ST_OUT_C: begin
                if (slot_free) begin
                    n_ov           = 1'b1;
                    n_od.status    = ST_OK;
                    n_od.rank_pos  = r_k;
                    n_od.bin_value = r_ro;
                    n_od.bin_count = cap_count(cnt_a);
                    n_od.last      = (r_k == last_idx);
                    if (r_k == last_idx) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_OUT_A;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_vq    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_vq    <= b_en;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_od   <= n_od;
        r_pool <= n_pool;
        r_val  <= n_val;
        r_i    <= n_i;
        r_j    <= n_j;
        r_jq   <= r_j;
        r_k    <= n_k;
        r_pos  <= n_pos;
    end

    // Count store valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld[w_addr] <= 1'b1;
        end
    end

    // Count store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (a_en) begin
            r_rda   <= r_mem[a_addr];
            r_rda_v <= r_vld[a_addr];
        end
        if (b_en) begin
            r_rdb   <= r_mem[b_addr];
            r_rdb_v <= r_vld[b_addr];
        end
    end

    // Rank order store
    always_ff @(posedge i_clk) begin
        if (ro_wen) begin
            r_ro_mem[n_pos] <= r_i;
        end
        if (r_state == ST_OUT_A) begin
            r_ro <= r_ro_mem[r_k];
        end
    end

    // Checks
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && (r_od.status == ST_REJECT) |-> (r_od.bin_count == 8'd0) && r_od.last)
        else $error("rejected add carries a count");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_req.ready)
        else $error("request taken while another is in work");

    a_place_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RK_I) |-> (r_i <= last_idx))
        else $error("placed bin beyond pool size");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT_A) |-> (r_k <= last_idx))
        else $error("rank position beyond pool size");

endmodule

FILE: tb/sv/tb_histogram_frequency_ranker.sv
// Self-checking testbench for histogram_frequency_ranker: drives add and ranking
// requests, predicts every result word and compares them in order.
// Depends on hfr_pkg, hfr_req_if, hfr_res_if and the block itself.
`timescale 1ns / 1ps

module tb_histogram_frequency_ranker;
    import hfr_pkg::*;

    localparam int MAIN_N    = 64;
    localparam int BONUS_N   = 32;
    localparam int CNT_MAX   = 255;
    localparam int WDOG_MAX  = 20000;
    localparam int HOLD_LONG = 300;

    logic i_clk;
    logic i_rst_n;

    hfr_req_if req_ch ();
    hfr_res_if res_ch ();

    histogram_frequency_ranker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    // predictor state
    int   main_cnt  [64];
    int   bonus_cnt [64];
    t_req req_q     [$];
    t_res exp_q     [$];

    int  n_err;
    int  wdog;
    bit  done_feed;
    bit  quiet;          // no idling near the end
    bit  src_hold;       // sender pauses until drained
    int  sink_hold_req;  // long receiver hold-off request
    int  src_gap, sink_gap, sink_long;

    // work out the result words of one accepted request
    task automatic predict_req(input t_req r);
        t_res w;
        int   n, pos, c;
        int   order [64];
        if (r.req_type == REQ_ADD) begin
            n = r.pool ? BONUS_N : MAIN_N;
            w = '0;
            w.bin_value = r.sample_value;
            w.last = 1'b1;
            if (r.sample_value == 0 || r.sample_value >= n) begin
                w.status = ST_REJECT;
            end else begin
                if (r.pool) begin
                    if (bonus_cnt[r.sample_value] < CNT_MAX)
                        bonus_cnt[r.sample_value]++;
                    c = bonus_cnt[r.sample_value];
                end else begin
                    if (main_cnt[r.sample_value] < CNT_MAX)
                        main_cnt[r.sample_value]++;
                    c = main_cnt[r.sample_value];
                end
                w.status = ST_OK;
                w.bin_count = c[7:0];
            end
            exp_q.push_back(w);
        end else begin
            n = r.pool ? BONUS_N : MAIN_N;
            for (int i = 0; i < n; i++) begin
                pos = 0;
                c = r.pool ? bonus_cnt[i] : main_cnt[i];
                for (int j = 0; j < n; j++) begin
                    int cj;
                    cj = r.pool ? bonus_cnt[j] : main_cnt[j];
                    if (cj > c || (cj == c && j < i)) pos++;
                end
                order[pos] = i;
            end
            for (int i = 0; i < n; i++) begin
                w = '0;
                w.status = ST_OK;
                w.rank_pos = i[5:0];
                w.bin_value = order[i][5:0];
                c = r.pool ? bonus_cnt[order[i]] : main_cnt[order[i]];
                w.bin_count = c[7:0];
                w.last = (i == n - 1);
                exp_q.push_back(w);
            end
        end
    endtask

    function automatic t_req mk_req(input logic rt, input logic pl, input int v);
        t_req r;
        r.req_type = rt;
        r.pool = pl;
        r.sample_value = v[5:0];
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // stimulus: fill the pending queue
    initial begin
        int v;
        i_rst_n = 1'b0;
        quiet = 1'b0;
        done_feed = 1'b0;
        // directed: extremes, rejects, both pools, ranking on empty pools
        req_q.push_back(mk_req(REQ_RANK, 1'b0, 0));
        req_q.push_back(mk_req(REQ_RANK, 1'b1, 63));
        req_q.push_back(mk_req(REQ_ADD, 1'b0, 0));
        req_q.push_back(mk_req(REQ_ADD, 1'b1, 0));
        req_q.push_back(mk_req(REQ_ADD, 1'b0, 63));
        req_q.push_back(mk_req(REQ_ADD, 1'b0, 1));
        req_q.push_back(mk_req(REQ_ADD, 1'b1, 31));
        req_q.push_back(mk_req(REQ_ADD, 1'b1, 32));
        req_q.push_back(mk_req(REQ_ADD, 1'b1, 63));
        req_q.push_back(mk_req(REQ_ADD, 1'b1, 1));
        req_q.push_back(mk_req(REQ_ADD, 1'b0, 42));
        req_q.push_back(mk_req(REQ_ADD, 1'b0, 21));
        req_q.push_back(mk_req(REQ_ADD, 1'b0, 21));
        req_q.push_back(mk_req(REQ_RANK, 1'b0, 21));
        req_q.push_back(mk_req(REQ_RANK, 1'b1, 5));
        // random: mostly valid adds, skewed to few bins, occasional rankings
        for (int k = 0; k < 180; k++) begin
            v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                            : $urandom_range(1, 8);
            if ($urandom_range(0, 24) == 0)
                req_q.push_back(mk_req(REQ_RANK, 1'($urandom_range(0, 1)), v));
            else
                req_q.push_back(mk_req(REQ_ADD, 1'($urandom_range(0, 1)), v));
        end
        // final rankings of both pools
        req_q.push_back(mk_req(REQ_RANK, 1'b0, 0));
        req_q.push_back(mk_req(REQ_RANK, 1'b1, 0));
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver
    int sent;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
            src_gap  <= 0;
            src_hold <= 1'b0;
            sent     <= 0;
            sink_hold_req <= 0;
        end else begin
            int left;
            bit fire;
            fire = req_ch.valid && req_ch.ready;
            if (fire) begin
                predict_req(req_ch.data);
                sent <= sent + 1;
                // long receiver hold-off once, with the sender still offering
                if (sent == 40) sink_hold_req <= HOLD_LONG;
                // sender pause until every expected word has come back
                if (sent == 120) src_hold <= 1'b1;
            end else begin
                sink_hold_req <= 0;
            end
            left = req_q.size();
            if (src_hold && exp_q.size() == 0 && !fire) src_hold <= 1'b0;
            if (req_ch.valid && !fire) begin
                // keep offering
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                req_ch.valid <= 1'b0;
            end else if (left == 0 || src_hold || (fire && sent == 120)) begin
                req_ch.valid <= 1'b0;
                if (left == 0) done_feed <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                src_gap <= $urandom_range(1, 6) - 1;
                req_ch.valid <= 1'b0;
            end else begin
                req_ch.data  <= req_q.pop_front();
                req_ch.valid <= 1'b1;
            end
            quiet <= (left < 40);
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            sink_gap  <= 0;
            sink_long <= 0;
            n_err     <= 0;
            wdog      <= 0;
        end else begin
            t_res e;
            if (res_ch.valid && res_ch.ready) begin
                if (exp_q.size() == 0) begin
                    n_err <= n_err + 1;
                    if (n_err < 10)
                        $display("ERROR: unexpected result word %p", res_ch.data);
                end else begin
                    e = exp_q.pop_front();
                    if (res_ch.data !== e) begin
                        n_err <= n_err + 1;
                        if (n_err < 10)
                            $display("ERROR: result mismatch exp %p got %p",
                                     e, res_ch.data);
                    end
                end
            end
            if ((res_ch.valid && res_ch.ready) || (req_ch.valid && req_ch.ready))
                wdog <= 0;
            else
                wdog <= wdog + 1;
            if (sink_hold_req > 0) begin
                sink_long <= sink_hold_req;
                res_ch.ready <= 1'b0;
            end else if (sink_long > 0) begin
                sink_long <= sink_long - 1;
                res_ch.ready <= (sink_long == 1);
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                res_ch.ready <= (sink_gap == 1);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(1, 6);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // end of run
    initial begin
        @(posedge i_rst_n);
        while (!(done_feed && exp_q.size() == 0) && wdog < WDOG_MAX)
            @(posedge i_clk);
        if (wdog >= WDOG_MAX) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            repeat (50) @(posedge i_clk);
            if (n_err == 0 && exp_q.size() == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
            $finish;
        end
    end

endmodule

FILE: files.f
rtl/hfr_pkg.sv
rtl/hfr_req_if.sv
rtl/hfr_res_if.sv
rtl/histogram_frequency_ranker.sv
tb/sv/tb_histogram_frequency_ranker.sv
